### hw/rtl/ttcw_pkg.sv
// ttcw_pkg: shared types and constants of the text terminal cell writer
// request and response items, cell layout, request and control codes
// no dependencies
package ttcw_pkg;

	localparam int CURSOR_ROW_W = 5;
	localparam int CURSOR_COL_W = 7;
	localparam int CFG_INDEX_W = 2;

	localparam logic [31:0] TEXT_COLOR_RESET = 32'h00E4_30FF;
	localparam logic [31:0] BACK_COLOR_RESET = 32'h0000_0000;

	localparam logic [2:0] REQ_PUT_BYTE = 3'd0;
	localparam logic [2:0] REQ_SET_CURSOR = 3'd1;
	localparam logic [2:0] REQ_CLEAR = 3'd2;
	localparam logic [2:0] REQ_READ_CELL = 3'd3;
	localparam logic [2:0] REQ_WRITE_CELL = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLOR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACK_COLOR = 2'd1;

	localparam logic [7:0] CH_BEEP = 8'd7;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LINE_FEED = 8'd10;
	localparam logic [7:0] CH_CARRIAGE_RET = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_INVERSE_ON = 8'd134;
	localparam logic [7:0] CH_INVERSE_OFF = 8'd135;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] char_code;
		logic signed [7:0] row;
		logic signed [7:0] col;
		logic [31:0] fore_color;
		logic [31:0] back_color_in;
	} req_t;

	typedef struct packed {
		logic [CURSOR_ROW_W-1:0] cursor_row;
		logic [CURSOR_COL_W-1:0] cursor_col;
		logic inverse_mode;
		logic cell_valid;
		logic [7:0] cell_char;
		logic [31:0] cell_fore;
		logic [31:0] cell_back;
		logic cell_inverse;
	} rsp_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [31:0] fore;
		logic [31:0] back;
	} cell_t;

	typedef struct packed {
		logic data;
		logic inv;
	} mem_we_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_TAB,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESP
	} ctrl_state_t;

endpackage

### hw/rtl/ttcw_mem.sv
// ttcw_mem: screen storage, one cell memory and one inverse flag memory
// one write port and one registered read port each, shared addresses
// depends on ttcw_pkg
module ttcw_mem #(
	parameter int DEPTH = 1768,
	parameter int ADDR_W = 11
) (
	input  logic                clk,
	input  logic [ADDR_W-1:0]   raddr,
	output ttcw_pkg::cell_t     rdata,
	output logic                rinv,
	input  logic [ADDR_W-1:0]   waddr,
	input  ttcw_pkg::mem_we_t   wen,
	input  ttcw_pkg::cell_t     wdata,
	input  logic                winv
);

	ttcw_pkg::cell_t cell_mem [DEPTH];
	logic            inv_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wen.data) begin
			cell_mem[waddr] <= wdata;
		end
		rdata <= cell_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (wen.inv) begin
			inv_mem[waddr] <= winv;
		end
		rinv <= inv_mem[raddr];
	end

endmodule

### hw/rtl/ttcw_ctrl.sv
// ttcw_ctrl: request sequencer, cursor and inverse state, scroll and clear sweeps
// drives the screen memories and holds the response register
// depends on ttcw_pkg
module ttcw_ctrl #(
	parameter int SCREEN_COLS = 68,
	parameter int SCREEN_ROWS = 26,
	parameter int TAB_STOP = 4,
	parameter int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS,
	parameter int ADDR_W = $clog2(CELL_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ttcw_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ttcw_pkg::rsp_t      rsp,
	input  logic [31:0]         text_color,
	input  logic [31:0]         back_color,
	output logic [ADDR_W-1:0]   mem_raddr,
	input  ttcw_pkg::cell_t     mem_rdata,
	input  logic                mem_rinv,
	output logic [ADDR_W-1:0]   mem_waddr,
	output ttcw_pkg::mem_we_t   mem_wen,
	output ttcw_pkg::cell_t     mem_wdata,
	output logic                mem_winv
);

	localparam int ROW_W = $clog2(SCREEN_ROWS);
	localparam int COL_W = $clog2(SCREEN_COLS);
	localparam int COL_SPAN = 2 ** COL_W;

	ttcw_pkg::ctrl_state_t state_q, state_d;

	ttcw_pkg::req_t    req_q;
	logic [ROW_W-1:0]  cursor_row_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic              inverse_q;
	logic              hit_q;
	ttcw_pkg::cell_t   cell_q;
	logic              cell_inv_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic              init_q;
	logic              copy_q;
	logic              valid_s1;
	logic              copy_s1;
	logic [ADDR_W-1:0] addr_s1;
	ttcw_pkg::rsp_t    rsp_q;
	logic              rsp_valid_q;

	logic [COL_SPAN-1:0] tab_hit;
	logic [7:0]          row_u, col_u;
	logic                req_on_screen;
	logic [ADDR_W-1:0]   req_addr, cur_addr;
	logic                col_last, row_zero, row_top;
	logic [COL_W-1:0]    col_inc;
	logic                is_newline, is_tab, is_bs, is_inv_on, is_inv_off, is_plain;
	logic                sweep_has_src;
	logic                rsp_take;
	logic                sweep_start;
	logic [31:0]         blank_fore, blank_back;
	logic [ROW_W-1:0]    clamp_row;
	logic [COL_W-1:0]    clamp_col;

	for (genvar g = 0; g < COL_SPAN; g++) begin : g_tab
		assign tab_hit[g] = ((g % TAB_STOP) == 0);
	end

	assign row_u = req_q.row;
	assign col_u = req_q.col;
	assign req_on_screen = !row_u[7] && !col_u[7] && (row_u < 8'(SCREEN_ROWS))
		&& (col_u < 8'(SCREEN_COLS));
	assign req_addr = ADDR_W'(ADDR_W'(row_u[ROW_W-1:0]) * ADDR_W'(SCREEN_COLS)
		+ ADDR_W'(col_u[COL_W-1:0]));
	assign cur_addr = ADDR_W'(ADDR_W'(cursor_row_q) * ADDR_W'(SCREEN_COLS)
		+ ADDR_W'(cursor_col_q));

	assign col_last = cursor_col_q == COL_W'(SCREEN_COLS - 1);
	assign row_zero = cursor_row_q == '0;
	assign row_top = cursor_row_q == ROW_W'(SCREEN_ROWS - 1);
	assign col_inc = cursor_col_q + COL_W'(1);

	assign is_newline = (req_q.char_code == ttcw_pkg::CH_LINE_FEED)
		|| (req_q.char_code == ttcw_pkg::CH_CARRIAGE_RET);
	assign is_tab = req_q.char_code == ttcw_pkg::CH_TAB;
	assign is_bs = req_q.char_code == ttcw_pkg::CH_BACKSPACE;
	assign is_inv_on = req_q.char_code == ttcw_pkg::CH_INVERSE_ON;
	assign is_inv_off = req_q.char_code == ttcw_pkg::CH_INVERSE_OFF;
	assign is_plain = !is_newline && !is_tab && !is_bs && !is_inv_on && !is_inv_off
		&& (req_q.char_code != ttcw_pkg::CH_BEEP);

	always_comb begin
		if (row_u[7]) begin
			clamp_row = '0;
		end else if (row_u >= 8'(SCREEN_ROWS)) begin
			clamp_row = ROW_W'(SCREEN_ROWS - 1);
		end else begin
			clamp_row = row_u[ROW_W-1:0];
		end
		if (col_u[7]) begin
			clamp_col = '0;
		end else if (col_u >= 8'(SCREEN_COLS)) begin
			clamp_col = COL_W'(SCREEN_COLS - 1);
		end else begin
			clamp_col = col_u[COL_W-1:0];
		end
	end

	assign sweep_has_src = copy_q && (sweep_addr_q >= ADDR_W'(SCREEN_COLS));
	assign rsp_take = (state_q == ttcw_pkg::ST_RESP) && (!rsp_valid_q || rsp_ready);
	assign sweep_start = (state_d == ttcw_pkg::ST_SWEEP) && (state_q != ttcw_pkg::ST_SWEEP);
	assign blank_fore = init_q ? ttcw_pkg::TEXT_COLOR_RESET : text_color;
	assign blank_back = init_q ? ttcw_pkg::BACK_COLOR_RESET : back_color;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttcw_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = ttcw_pkg::ST_EXEC;
				end
			end
			ttcw_pkg::ST_EXEC: begin
				priority case (req_q.req_type)
					ttcw_pkg::REQ_PUT_BYTE: begin
						if (is_tab) begin
							state_d = ttcw_pkg::ST_TAB;
						end else if (row_zero && (is_newline || (is_plain && col_last))) begin
							state_d = ttcw_pkg::ST_SWEEP;
						end else begin
							state_d = ttcw_pkg::ST_RESP;
						end
					end
					ttcw_pkg::REQ_CLEAR:     state_d = ttcw_pkg::ST_SWEEP;
					ttcw_pkg::REQ_READ_CELL: state_d = ttcw_pkg::ST_READ;
					default:                 state_d = ttcw_pkg::ST_RESP;
				endcase
			end
			ttcw_pkg::ST_TAB: begin
				if (col_last) begin
					state_d = row_zero ? ttcw_pkg::ST_SWEEP : ttcw_pkg::ST_RESP;
				end else if (tab_hit[col_inc]) begin
					state_d = ttcw_pkg::ST_RESP;
				end
			end
			ttcw_pkg::ST_READ: state_d = ttcw_pkg::ST_RESP;
			ttcw_pkg::ST_SWEEP: begin
				if (sweep_addr_q == '0) begin
					state_d = ttcw_pkg::ST_DRAIN;
				end
			end
			ttcw_pkg::ST_DRAIN: state_d = init_q ? ttcw_pkg::ST_IDLE : ttcw_pkg::ST_RESP;
			ttcw_pkg::ST_RESP: begin
				if (rsp_take) begin
					state_d = ttcw_pkg::ST_IDLE;
				end
			end
			default: state_d = ttcw_pkg::ST_IDLE;
		endcase
	end

	// memory and handshake outputs
	always_comb begin
		req_ready = state_q == ttcw_pkg::ST_IDLE;
		mem_raddr = (state_q == ttcw_pkg::ST_SWEEP)
			? ADDR_W'(sweep_addr_q - ADDR_W'(SCREEN_COLS)) : req_addr;
		mem_waddr = cur_addr;
		mem_wen = '0;
		mem_wdata.ch = ttcw_pkg::CH_SPACE;
		mem_wdata.fore = inverse_q ? back_color : text_color;
		mem_wdata.back = inverse_q ? text_color : back_color;
		mem_winv = inverse_q;
		if (valid_s1) begin
			mem_waddr = addr_s1;
			mem_wen.data = 1'b1;
			mem_wen.inv = 1'b1;
			if (copy_s1) begin
				mem_wdata = mem_rdata;
				mem_winv = mem_rinv;
			end else begin
				mem_wdata.fore = blank_fore;
				mem_wdata.back = blank_back;
				mem_winv = !init_q && inverse_q;
			end
		end else if (state_q == ttcw_pkg::ST_TAB) begin
			mem_wen.data = 1'b1;
		end else if (state_q == ttcw_pkg::ST_EXEC) begin
			if (req_q.req_type == ttcw_pkg::REQ_PUT_BYTE && is_plain) begin
				mem_wen.data = 1'b1;
				mem_wdata.ch = req_q.char_code;
			end else if (req_q.req_type == ttcw_pkg::REQ_WRITE_CELL && req_on_screen) begin
				mem_wen.data = 1'b1;
				mem_waddr = req_addr;
				mem_wdata.ch = req_q.char_code;
				mem_wdata.fore = inverse_q ? req_q.back_color_in : req_q.fore_color;
				mem_wdata.back = inverse_q ? req_q.fore_color : req_q.back_color_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttcw_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			inverse_q <= 1'b0;
			hit_q <= 1'b0;
			sweep_addr_q <= ADDR_W'(CELL_COUNT - 1);
			init_q <= 1'b1;
			copy_q <= 1'b0;
			valid_s1 <= 1'b0;
			copy_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			valid_s1 <= state_q == ttcw_pkg::ST_SWEEP;
			copy_s1 <= sweep_has_src;
			if (sweep_start) begin
				sweep_addr_q <= ADDR_W'(CELL_COUNT - 1);
				init_q <= 1'b0;
				copy_q <= req_q.req_type == ttcw_pkg::REQ_PUT_BYTE;
			end else if (state_q == ttcw_pkg::ST_SWEEP) begin
				sweep_addr_q <= sweep_addr_q - ADDR_W'(1);
			end
			unique case (state_q)
				ttcw_pkg::ST_IDLE: begin
					if (req_valid) begin
						hit_q <= 1'b0;
					end
				end
				ttcw_pkg::ST_EXEC: begin
					priority case (req_q.req_type)
						ttcw_pkg::REQ_PUT_BYTE: begin
							if (is_newline || (is_plain && col_last)) begin
								cursor_row_q <= row_zero ? cursor_row_q : cursor_row_q - ROW_W'(1);
								cursor_col_q <= '0;
							end else if (is_plain) begin
								cursor_col_q <= col_inc;
							end else if (is_bs) begin
								if (cursor_col_q != '0) begin
									cursor_col_q <= cursor_col_q - COL_W'(1);
								end else if (!row_top) begin
									cursor_row_q <= cursor_row_q + ROW_W'(1);
									cursor_col_q <= COL_W'(SCREEN_COLS - 1);
								end
							end else if (is_inv_on) begin
								inverse_q <= 1'b1;
							end else if (is_inv_off) begin
								inverse_q <= 1'b0;
							end
						end
						ttcw_pkg::REQ_SET_CURSOR: begin
							cursor_row_q <= clamp_row;
							cursor_col_q <= clamp_col;
						end
						ttcw_pkg::REQ_READ_CELL: hit_q <= req_on_screen;
						default: ;
					endcase
				end
				ttcw_pkg::ST_TAB: begin
					if (col_last) begin
						cursor_row_q <= row_zero ? cursor_row_q : cursor_row_q - ROW_W'(1);
						cursor_col_q <= '0;
					end else begin
						cursor_col_q <= col_inc;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == ttcw_pkg::ST_READ) begin
			cell_q <= mem_rdata;
			cell_inv_q <= mem_rinv;
		end
		addr_s1 <= sweep_addr_q;
		if (rsp_take) begin
			rsp_q.cursor_row <= ttcw_pkg::CURSOR_ROW_W'(cursor_row_q);
			rsp_q.cursor_col <= ttcw_pkg::CURSOR_COL_W'(cursor_col_q);
			rsp_q.inverse_mode <= inverse_q;
			rsp_q.cell_valid <= hit_q;
			rsp_q.cell_char <= hit_q ? cell_q.ch : 8'd0;
			rsp_q.cell_fore <= hit_q ? cell_q.fore : 32'd0;
			rsp_q.cell_back <= hit_q ? cell_q.back : 32'd0;
			rsp_q.cell_inverse <= hit_q && cell_inv_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

### hw/rtl/text_terminal_cell_writer_top.sv
// text_terminal_cell_writer_top: character-cell terminal, color registers and core
// a request passes exec and resp; a read adds a read state, a tab the tab state
// a new request is taken only back in idle; scroll and clear sweep the screen
// memory, one cell per cycle through its separate read and write ports
// reset: clearing pass over every cell with req_ready low, cfg writes taken
// depends on ttcw_pkg, ttcw_mem, ttcw_ctrl
module text_terminal_cell_writer_top #(
	parameter int SCREEN_COLS = 68,
	parameter int SCREEN_ROWS = 26,
	parameter int TAB_STOP = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  ttcw_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output ttcw_pkg::rsp_t                      rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ttcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data
);

	localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W = $clog2(CELL_COUNT);

	logic [31:0]       text_color_q;
	logic [31:0]       back_color_q;
	logic [ADDR_W-1:0] mem_raddr, mem_waddr;
	ttcw_pkg::cell_t   mem_rdata, mem_wdata;
	logic              mem_rinv, mem_winv;
	ttcw_pkg::mem_we_t mem_wen;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= ttcw_pkg::TEXT_COLOR_RESET;
			back_color_q <= ttcw_pkg::BACK_COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ttcw_pkg::CFG_TEXT_COLOR) begin
				text_color_q <= cfg_data;
			end else if (cfg_index == ttcw_pkg::CFG_BACK_COLOR) begin
				back_color_q <= cfg_data;
			end
		end
	end

	ttcw_mem #(
		.DEPTH  (CELL_COUNT),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.rinv  (mem_rinv),
		.waddr (mem_waddr),
		.wen   (mem_wen),
		.wdata (mem_wdata),
		.winv  (mem_winv)
	);

	ttcw_ctrl #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.TAB_STOP    (TAB_STOP),
		.CELL_COUNT  (CELL_COUNT),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.text_color (text_color_q),
		.back_color (back_color_q),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.mem_rinv   (mem_rinv),
		.mem_waddr  (mem_waddr),
		.mem_wen    (mem_wen),
		.mem_wdata  (mem_wdata),
		.mem_winv   (mem_winv)
	);

endmodule
